FILE: src/nibble_delta_yuv_unpacker_macros.svh
// assertion macros for the nibble delta yuv unpacker
`ifndef NIBBLE_DELTA_YUV_UNPACKER_MACROS_SVH
`define NIBBLE_DELTA_YUV_UNPACKER_MACROS_SVH

// same-cycle implication, checked out of reset
`define NUD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nud check failed");

// next-cycle implication, checked out of reset
`define NUD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nud check failed");

`endif

FILE: src/nud_pkg.sv
// package with types, limits and code decode functions of the yuv unpacker
`timescale 1ns / 1ps
package nud_pkg;

  typedef logic [7:0] pix_t;
  typedef logic [3:0] code_t;

  localparam pix_t LumaMin    = 8'd16;
  localparam pix_t LumaMax    = 8'd235;
  localparam pix_t ChromaMin  = 8'd16;
  localparam pix_t ChromaMax  = 8'd240;
  localparam pix_t LumaInit   = 8'h10;
  localparam pix_t ChromaInit = 8'h80;

  localparam code_t CodeDeltaHi = 4'h2;
  localparam code_t CodeDeltaLo = 4'he;

  // per code: value to add or absolute base level
  function automatic pix_t code_value(input code_t code);
    pix_t v;
    case (code)
      4'h0:    v = 8'h00;
      4'h1:    v = 8'h02;
      4'h2:    v = 8'h08;
      4'h3:    v = 8'h1c;
      4'h4:    v = 8'h30;
      4'h5:    v = 8'h44;
      4'h6:    v = 8'h58;
      4'h7:    v = 8'h6c;
      4'h8:    v = 8'h80;
      4'h9:    v = 8'h94;
      4'ha:    v = 8'ha8;
      4'hb:    v = 8'hbc;
      4'hc:    v = 8'hd0;
      4'hd:    v = 8'he4;
      4'he:    v = 8'hf8;
      4'hf:    v = 8'hfe;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // delta codes wrap modulo 256, level codes keep the old lsb
  function automatic pix_t apply_code(input pix_t prev, input code_t code);
    pix_t r;
    if (code <= CodeDeltaHi || code >= CodeDeltaLo) begin
      r = prev + code_value(code);
    end else begin
      r = code_value(code) + {7'd0, prev[0]};
    end
    return r;
  endfunction

  function automatic pix_t clamp_to(input pix_t v, input pix_t lo, input pix_t hi);
    pix_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: src/nibble_delta_yuv_unpacker.sv
// top level of the nibble delta yuv unpacker: input register, decode, result register
`timescale 1ns / 1ps
`include "nibble_delta_yuv_unpacker_macros.svh"

// Decodes one packed byte per item into a luma value and one chroma value
// (U and V alternate, flagged by chroma_is_v_o). The block sustains one item
// per clock cycle while the output is not stalled; an accepted item moves from
// the input register into the result register, which drives the output. The
// running luma, both chroma stores and the U/V selector are updated as an
// item moves from the input register into the result register, so the decode
// of one item feeds the next item directly. A held output stalls the result
// register only; the input register still takes one more item, so upstream
// stalls only once the input register is full as well.
// A line start on an item resets luma to 16, both chroma stores to 128 and
// the selector to U before that item is decoded.
module nibble_delta_yuv_unpacker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  nud_pkg::pix_t code_byte_i,
  input  logic          line_start_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output nud_pkg::pix_t luma_o,
  output nud_pkg::pix_t chroma_o,
  output logic          chroma_is_v_o
);
  import nud_pkg::*;

  // input register
  logic  in_valid_q;
  pix_t  in_byte_q;
  logic  in_start_q;

  // decode state
  pix_t  luma_q;
  pix_t  chroma_u_q;
  pix_t  chroma_v_q;
  logic  sel_q;

  // result register
  logic  out_valid_q;
  pix_t  luma_out_q;
  pix_t  chroma_out_q;
  logic  is_v_out_q;

  logic  res_hold;
  logic  advance;
  logic  in_take;

  // decode path
  logic  sel_d;
  pix_t  luma_prev;
  pix_t  chroma_prev;
  pix_t  luma_d;
  pix_t  chroma_d;
  pix_t  chroma_u_base;
  pix_t  chroma_v_base;

  // result register is full and not drained this cycle
  assign res_hold   = out_valid_q && out_stall_i;
  assign advance    = in_valid_q && !res_hold;
  // input register can refill when empty or moving on
  assign in_stall_o = in_valid_q && res_hold;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    // line start puts everything back to the reset levels first
    sel_d         = in_start_q ? 1'b0 : sel_q;
    luma_prev     = in_start_q ? LumaInit : luma_q;
    chroma_u_base = in_start_q ? ChromaInit : chroma_u_q;
    chroma_v_base = in_start_q ? ChromaInit : chroma_v_q;
    chroma_prev   = sel_d ? chroma_v_base : chroma_u_base;

    luma_d   = clamp_to(apply_code(luma_prev, in_byte_q[3:0]), LumaMin, LumaMax);
    chroma_d = clamp_to(apply_code(chroma_prev, in_byte_q[7:4]), ChromaMin, ChromaMax);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      luma_q      <= LumaInit;
      chroma_u_q  <= ChromaInit;
      chroma_v_q  <= ChromaInit;
      sel_q       <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (!res_hold) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        luma_q <= luma_d;
        // the store not used still takes its line-start reset
        chroma_u_q <= sel_d ? chroma_u_base : chroma_d;
        chroma_v_q <= sel_d ? chroma_d : chroma_v_base;
        sel_q      <= !sel_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= code_byte_i;
      in_start_q <= line_start_i;
    end
    if (advance) begin
      luma_out_q   <= luma_d;
      chroma_out_q <= chroma_d;
      is_v_out_q   <= sel_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign luma_o        = luma_out_q;
  assign chroma_o      = chroma_out_q;
  assign chroma_is_v_o = is_v_out_q;

  `NUD_ASSERT_NOW(a_luma_range, out_valid_o, luma_o >= LumaMin && luma_o <= LumaMax)
  `NUD_ASSERT_NOW(a_chroma_range, out_valid_o, chroma_o >= ChromaMin && chroma_o <= ChromaMax)
  `NUD_ASSERT_NEXT(a_start_is_u, advance && in_start_q, out_valid_o && !chroma_is_v_o)
  `NUD_ASSERT_NEXT(a_sel_toggles, advance, sel_q == !chroma_is_v_o)

endmodule
